// ===== rtl/htne_pkg.sv =====
// Package: shared types, character constants and keyword tables of the tag name extractor.
package htne_pkg;

    // Length field wide enough for any name buffer size from 8 to 64
    localparam int NAME_LEN_W = 7;

    // Character codes
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_BRK   = 8'h5B;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Raw text kinds
    localparam logic KIND_SCRIPT = 1'b0;
    localparam logic KIND_STYLE  = 1'b1;

    // Keyword lengths
    localparam logic [2:0] LEN_BANG   = 3'd3;
    localparam logic [2:0] LEN_SCRIPT = 3'd6;
    localparam logic [2:0] LEN_STYLE  = 3'd5;
    localparam logic [2:0] LEN_SYN_SCRIPT = 3'd7;
    localparam logic [2:0] LEN_SYN_STYLE  = 3'd6;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] tag_char;
        logic       char_valid;
        logic       last_of_tag;
        logic       name_truncated;
        logic       synthetic_close;
    } t_out_item;

    typedef enum logic [2:0] {
        M_TEXT,
        M_NAME,
        M_SKIP,
        M_COMMENT,
        M_RAW_WAIT,
        M_RAW_LT,
        M_RAW_CLOSE
    } t_mode;

    typedef enum logic [1:0] {
        CM_MATCHING,
        CM_SPACE,
        CM_FAILED
    } t_cstat;

    typedef enum logic [1:0] {
        B_IDLE,
        B_FETCH,
        B_SHOW
    } t_bstate;

    // Work handed from the parser to the output sequencer
    typedef struct packed {
        logic                  is_synth;
        logic                  raw_kind;
        logic                  overflow;
        logic [NAME_LEN_W-1:0] len;
    } t_cmd;

    function automatic logic [7:0] bang_char(logic [2:0] pos);
        case (pos)
            3'd0:    return "!";
            3'd1:    return "-";
            3'd2:    return "-";
            default: return CH_NUL;
        endcase
    endfunction

    function automatic logic [7:0] script_char(logic [2:0] pos);
        case (pos)
            3'd0:    return "s";
            3'd1:    return "c";
            3'd2:    return "r";
            3'd3:    return "i";
            3'd4:    return "p";
            3'd5:    return "t";
            default: return CH_NUL;
        endcase
    endfunction

    function automatic logic [7:0] style_char(logic [2:0] pos);
        case (pos)
            3'd0:    return "s";
            3'd1:    return "t";
            3'd2:    return "y";
            3'd3:    return "l";
            3'd4:    return "e";
            default: return CH_NUL;
        endcase
    endfunction

    // Character of the generated close name: '/' then the keyword
    function automatic logic [7:0] synth_char(logic kind, logic [2:0] pos);
        logic [2:0] p;
        p = pos - 3'd1;
        if (pos == 3'd0) return CH_SLASH;
        return (kind == KIND_STYLE) ? style_char(p) : script_char(p);
    endfunction

    function automatic logic is_delim(logic [7:0] c);
        return c inside {CH_GT, CH_SP, CH_BRK, CH_LF, CH_CR, CH_NUL};
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c inside {CH_SP, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    endfunction

endpackage

// ===== rtl/htne_ifs.sv =====
// Interfaces: byte input channel and tag character output channel.
interface htne_in_if;
    logic               valid;
    logic               ready;
    htne_pkg::t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface htne_out_if;
    logic                valid;
    logic                ready;
    htne_pkg::t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== rtl/htne_cmd_fifo.sv =====
// Two-entry command queue between the parser and the output sequencer.
module htne_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  htne_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output htne_pkg::t_cmd o_cmd,
    output logic           o_empty
);
    import htne_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_q[r_rp];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_cmd;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/htne_front.sv =====
// Parser: takes input bytes, tracks the HTML parse mode and queues name and close emissions.
module htne_front #(
    parameter int MAX_TAG_LEN = 32,
    localparam int LW = $clog2(MAX_TAG_LEN + 1),
    localparam int AW = $clog2(MAX_TAG_LEN)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    htne_in_if.sink        i_in,
    output htne_pkg::t_cmd o_cmd,
    output logic           o_cmd_push,
    input  logic           i_cmd_full,
    output logic           o_wr_en,
    output logic [AW-1:0]  o_wr_addr,
    output logic [7:0]     o_wr_data,
    input  logic           i_name_done
);
    import htne_pkg::*;

    t_mode         r_mode,   n_mode;
    logic [LW-1:0] r_len,    n_len;
    logic          r_ovf,    n_ovf;
    logic [1:0]    r_dash,   n_dash;
    logic          r_raw,    n_raw;
    logic [2:0]    r_cpos,   n_cpos;
    t_cstat        r_cstat,  n_cstat;
    logic          r_m_bang, n_m_bang;
    logic          r_m_scr,  n_m_scr;
    logic          r_m_sty,  n_m_sty;
    logic          r_pend,   n_pend;

    logic       acc;
    logic [7:0] c;
    logic       is_scr, is_sty;
    t_mode      gt_mode;
    logic       gt_kind;
    logic [7:0] kw_c;
    logic [2:0] klen;

    // Hold input while a name is still being read out of the buffer or the queue is full
    assign i_in.ready = !r_pend && !i_cmd_full;
    assign acc        = i_in.valid && i_in.ready;
    assign c          = i_in.item.data_byte;

    // Buffered name against the raw text keywords, and the mode after '>'
    assign is_scr  = r_m_scr && !r_ovf && (r_len == LW'(LEN_SCRIPT));
    assign is_sty  = r_m_sty && !r_ovf && (r_len == LW'(LEN_STYLE));
    assign gt_mode = (is_scr || is_sty) ? M_RAW_WAIT : M_TEXT;
    assign gt_kind = is_sty ? KIND_STYLE : (is_scr ? KIND_SCRIPT : r_raw);

    assign kw_c = (r_raw == KIND_STYLE) ? style_char(r_cpos) : script_char(r_cpos);
    assign klen = (r_raw == KIND_STYLE) ? LEN_STYLE : LEN_SCRIPT;

    // Next state and queue writes
    always_comb begin
        n_mode   = r_mode;
        n_len    = r_len;
        n_ovf    = r_ovf;
        n_dash   = r_dash;
        n_raw    = r_raw;
        n_cpos   = r_cpos;
        n_cstat  = r_cstat;
        n_m_bang = r_m_bang;
        n_m_scr  = r_m_scr;
        n_m_sty  = r_m_sty;
        n_pend   = r_pend;
        o_cmd_push = 1'b0;
        o_cmd      = '{is_synth: 1'b0, raw_kind: KIND_SCRIPT, overflow: r_ovf,
                       len: NAME_LEN_W'(r_len)};
        o_wr_en    = 1'b0;
        o_wr_addr  = r_len[AW-1:0];
        o_wr_data  = c;

        if (acc) begin
            if (i_in.item.req_type) begin
                // End of stream: flush a pending name, back to reset values but for the keyword match flags
                if (r_mode == M_NAME) o_cmd_push = 1'b1;
                n_mode  = M_TEXT;
                n_len   = '0;
                n_ovf   = 1'b0;
                n_dash  = 2'd0;
                n_raw   = KIND_SCRIPT;
                n_cpos  = 3'd0;
                n_cstat = CM_MATCHING;
            end else begin
                case (r_mode)
                    M_NAME: begin
                        if (is_delim(c)) begin
                            o_cmd_push = 1'b1;
                            if (c == CH_GT) begin
                                n_mode = gt_mode;
                                n_raw  = gt_kind;
                            end else begin
                                n_mode = M_SKIP;
                            end
                        end else begin
                            if (r_len < LW'(MAX_TAG_LEN)) begin
                                o_wr_en  = 1'b1;
                                n_len    = r_len + LW'(1);
                                n_m_bang = r_m_bang && (r_len < LW'(LEN_BANG)) &&
                                           (c == bang_char(r_len[2:0]));
                                n_m_scr  = r_m_scr && (r_len < LW'(LEN_SCRIPT)) &&
                                           (c == script_char(r_len[2:0]));
                                n_m_sty  = r_m_sty && (r_len < LW'(LEN_STYLE)) &&
                                           (c == style_char(r_len[2:0]));
                            end else begin
                                n_ovf = 1'b1;
                            end
                            // Name "!--" opens a comment
                            if (!n_ovf && n_m_bang && (n_len == LW'(LEN_BANG))) begin
                                n_dash = 2'd0;
                                n_mode = M_COMMENT;
                            end
                        end
                    end
                    M_SKIP: begin
                        if (c == CH_GT) begin
                            n_mode = gt_mode;
                            n_raw  = gt_kind;
                        end
                    end
                    M_COMMENT: begin
                        if (c == CH_DASH) begin
                            if (r_dash != 2'd2) n_dash = r_dash + 2'd1;
                        end else if (c == CH_GT && r_dash == 2'd2) begin
                            n_dash = 2'd0;
                            n_mode = M_TEXT;
                        end else begin
                            n_dash = 2'd0;
                        end
                    end
                    M_RAW_WAIT: begin
                        if (c == CH_LT) n_mode = M_RAW_LT;
                    end
                    M_RAW_LT: begin
                        if (c == CH_SLASH) begin
                            n_cpos  = 3'd0;
                            n_cstat = CM_MATCHING;
                            n_mode  = M_RAW_CLOSE;
                        end else if (c != CH_LT) begin
                            n_mode = M_RAW_WAIT;
                        end
                    end
                    M_RAW_CLOSE: begin
                        if (c == CH_GT) begin
                            if (r_cstat != CM_FAILED && r_cpos == klen) begin
                                o_cmd_push = 1'b1;
                                o_cmd = '{is_synth: 1'b1, raw_kind: r_raw, overflow: 1'b0,
                                          len: NAME_LEN_W'((r_raw == KIND_STYLE) ?
                                               LEN_SYN_STYLE : LEN_SYN_SCRIPT)};
                                n_mode = M_TEXT;
                            end else begin
                                n_mode = M_RAW_WAIT;
                            end
                        end else if (c == CH_LT) begin
                            n_mode = M_RAW_LT;
                        end else if (r_cstat == CM_MATCHING) begin
                            if (r_cpos < klen && c == kw_c)     n_cpos  = r_cpos + 3'd1;
                            else if (r_cpos == klen && is_space(c)) n_cstat = CM_SPACE;
                            else                                 n_cstat = CM_FAILED;
                        end else if (r_cstat == CM_SPACE && !is_space(c)) begin
                            n_cstat = CM_FAILED;
                        end
                    end
                    default: begin
                        // Text: '<' starts a new name
                        if (c == CH_LT) begin
                            n_len    = '0;
                            n_ovf    = 1'b0;
                            n_m_bang = 1'b1;
                            n_m_scr  = 1'b1;
                            n_m_sty  = 1'b1;
                            n_mode   = M_NAME;
                        end
                    end
                endcase
            end
        end

        // Name readout in flight
        if (i_name_done) n_pend = 1'b0;
        if (o_cmd_push && !o_cmd.is_synth) n_pend = 1'b1;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_TEXT;
            r_len    <= '0;
            r_ovf    <= 1'b0;
            r_dash   <= 2'd0;
            r_raw    <= KIND_SCRIPT;
            r_cpos   <= 3'd0;
            r_cstat  <= CM_MATCHING;
            r_m_bang <= 1'b0;
            r_m_scr  <= 1'b0;
            r_m_sty  <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_len    <= n_len;
            r_ovf    <= n_ovf;
            r_dash   <= n_dash;
            r_raw    <= n_raw;
            r_cpos   <= n_cpos;
            r_cstat  <= n_cstat;
            r_m_bang <= n_m_bang;
            r_m_scr  <= n_m_scr;
            r_m_sty  <= n_m_sty;
            r_pend   <= n_pend;
        end
    end

endmodule

// ===== rtl/htne_back.sv =====
// Output sequencer: holds the name buffer and reads names or generated closes out one character at a time.
module htne_back #(
    parameter int MAX_TAG_LEN = 32,
    localparam int LW = $clog2(MAX_TAG_LEN + 1),
    localparam int AW = $clog2(MAX_TAG_LEN)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_en,
    input  logic [AW-1:0]  i_wr_addr,
    input  logic [7:0]     i_wr_data,
    input  htne_pkg::t_cmd i_cmd,
    input  logic           i_cmd_empty,
    output logic           o_cmd_pop,
    output logic           o_name_done,
    htne_out_if.source     o_out
);
    import htne_pkg::*;

    logic [7:0]    r_mem [MAX_TAG_LEN];
    logic [7:0]    r_rd;
    t_bstate       r_state, n_state;
    logic [LW-1:0] r_idx,   n_idx;
    t_cmd          r_cmd,   n_cmd;

    logic empty_name;
    logic last;

    // Name buffer: write from the parser, registered read at the current index
    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
        r_rd <= r_mem[r_idx[AW-1:0]];
    end

    assign empty_name = !r_cmd.is_synth && (r_cmd.len == '0);
    assign last       = empty_name ||
                        ((NAME_LEN_W'(r_idx) + NAME_LEN_W'(1)) == r_cmd.len);

    // Next state and output item
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cmd       = r_cmd;
        o_cmd_pop   = 1'b0;
        o_name_done = 1'b0;
        o_out.valid = 1'b0;
        o_out.item.tag_char        = r_cmd.is_synth ? synth_char(r_cmd.raw_kind, r_idx[2:0]) :
                                     (empty_name ? CH_NUL : r_rd);
        o_out.item.char_valid      = !empty_name;
        o_out.item.last_of_tag     = last;
        o_out.item.name_truncated  = !r_cmd.is_synth && r_cmd.overflow;
        o_out.item.synthetic_close = r_cmd.is_synth;

        case (r_state)
            B_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_idx     = '0;
                    n_state   = (i_cmd.is_synth || i_cmd.len == '0) ? B_SHOW : B_FETCH;
                end
            end
            B_FETCH: begin
                n_state = B_SHOW;
            end
            B_SHOW: begin
                o_out.valid = 1'b1;
                if (o_out.ready) begin
                    if (last) begin
                        n_state     = B_IDLE;
                        o_name_done = !r_cmd.is_synth;
                    end else begin
                        n_idx   = r_idx + LW'(1);
                        n_state = r_cmd.is_synth ? B_SHOW : B_FETCH;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Current command
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

endmodule

// ===== rtl/html_tag_name_extractor_top.sv =====
// Top level of the HTML tag name extractor: parser, command queue and output sequencer.
//
//  channel  interface      payload                                         direction
//  i_in     htne_in_if     req_type, data_byte                             in
//  o_out    htne_out_if    tag_char, char_valid, last_of_tag,
//                          name_truncated, synthetic_close                 out
//
// The parser takes one byte per cycle unless held. From the delimiter that ends a name
// until the last character of that name has been taken, input is held, since the name
// buffer is being read; input is also held while the command queue is full.
// The sequencer takes each queued command while idle, then reads each name character
// from the buffer before output; generated close characters go out directly.
// Reset is synchronous; the name buffer has no reset and needs no clearing pass.
// Output stalls hold the sequencer; the two-entry queue lets parsing run up to a name.
module html_tag_name_extractor_top #(
    parameter int MAX_TAG_LEN = 32
) (
    input logic         i_clk,
    input logic         i_rst_n,
    htne_in_if.sink     i_in,
    htne_out_if.source  o_out
);
    import htne_pkg::*;

    localparam int AW = $clog2(MAX_TAG_LEN);

    t_cmd          push_cmd, pop_cmd;
    logic          cmd_push, cmd_pop, cmd_full, cmd_empty;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          name_done;

    htne_front #(.MAX_TAG_LEN(MAX_TAG_LEN)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (push_cmd),
        .o_cmd_push  (cmd_push),
        .i_cmd_full  (cmd_full),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .i_name_done (name_done)
    );

    htne_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (push_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_cmd   (pop_cmd),
        .o_empty (cmd_empty)
    );

    htne_back #(.MAX_TAG_LEN(MAX_TAG_LEN)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_cmd       (pop_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_name_done (name_done),
        .o_out       (o_out)
    );

endmodule

// ===== rtl/htne_checker.sv =====
// Port checker for the tag name extractor, bound to the top level.
module htne_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input htne_pkg::t_out_item i_out_item
);
    import htne_pkg::*;

    // A stalled output item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))
        else $error("output item changed while stalled");

    // An empty name is a single, final item
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_item.char_valid |-> i_out_item.last_of_tag)
        else $error("empty name item not marked last");

    // Generated closes carry characters and are never truncated
    a_synth_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.synthetic_close |->
            i_out_item.char_valid && !i_out_item.name_truncated)
        else $error("bad flags on generated close");

    // A generated close runs on without a gap until its last character
    a_synth_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_item.synthetic_close &&
        !i_out_item.last_of_tag |=> i_out_valid && i_out_item.synthetic_close)
        else $error("generated close interrupted");

    // Nothing comes out in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind html_tag_name_extractor_top htne_checker u_htne_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_item  (o_out.item)
);

// ===== tb/testbench.sv =====
// Testbench of the HTML tag name extractor: directed rows, then random HTML fragments, checked
// against a byte-level parser written here.
module testbench;
    import htne_pkg::*;

    localparam int MAX_TAG_LEN  = 32;
    localparam int RAND_ITEMS   = 180;
    localparam int CALM_ITEMS   = 40;
    localparam int HOLD_CYCLES  = 150;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;

    // How a directed row is checked
    localparam logic [1:0] CHK_MODEL = 2'd0;  // parser below decides
    localparam logic [1:0] CHK_NONE  = 2'd1;  // no result
    localparam logic [1:0] CHK_ONE   = 2'd2;  // exactly the typed result

    typedef struct packed {
        t_in_item   item;
        logic [1:0] chk;
        t_out_item  res;
    } t_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    htne_in_if  byte_ch ();
    htne_out_if char_ch ();

    html_tag_name_extractor_top #(.MAX_TAG_LEN(MAX_TAG_LEN)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (char_ch)
    );

    always #2 i_clk = ~i_clk;

    // Parser state mirrored from the block
    t_mode      pmode;
    logic [7:0] nm_buf [MAX_TAG_LEN];
    int         nm_len;
    logic       nm_ovf;
    int         dash_run;
    logic       rkind;
    int         cl_pos;
    t_cstat     cl_stat;

    t_out_item  step_res[$];       // results of the byte just parsed
    t_out_item  pending_chars[$];  // tag characters still to come out
    t_row       dir_rows[$];
    t_in_item   frag[$];

    logic idle_on  = 1'b1;
    logic hold_req = 1'b0;
    int   n_sent = 0, n_eos = 0, n_chars = 0, n_names = 0, n_synth = 0, n_trunc = 0;
    int   n_err = 0;
    int   quiet_cycles = 0;

    function automatic t_out_item mk_res(input logic [7:0] ch, input logic v, input logic l,
                                         input logic t, input logic s);
        t_out_item r;
        r.tag_char        = ch;
        r.char_valid      = v;
        r.last_of_tag     = l;
        r.name_truncated  = t;
        r.synthetic_close = s;
        return r;
    endfunction

    function automatic logic ends_name(input logic [7:0] c);
        case (c)
            CH_GT, CH_SP, CH_BRK, CH_LF, CH_CR, CH_NUL: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        case (c)
            CH_SP, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Whole collected name equals kw; a truncated name never matches
    function automatic logic name_is(input string kw);
        if (nm_ovf || nm_len != kw.len()) return 1'b0;
        for (int i = 0; i < kw.len(); i++) begin
            if (nm_buf[i] != kw[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Mode after the '>' that closes a tag; script and style open raw text
    function automatic t_mode mode_after_gt();
        if (name_is("script")) begin
            rkind = KIND_SCRIPT;
            return M_RAW_WAIT;
        end
        if (name_is("style")) begin
            rkind = KIND_STYLE;
            return M_RAW_WAIT;
        end
        return M_TEXT;
    endfunction

    task automatic reset_parser();
        pmode    = M_TEXT;
        nm_len   = 0;
        nm_ovf   = 1'b0;
        dash_run = 0;
        rkind    = KIND_SCRIPT;
        cl_pos   = 0;
        cl_stat  = CM_MATCHING;
    endtask

    task automatic push_name();
        if (nm_len == 0) begin
            step_res.push_back(mk_res(CH_NUL, 1'b0, 1'b1, nm_ovf, 1'b0));
        end else begin
            for (int i = 0; i < nm_len; i++)
                step_res.push_back(mk_res(nm_buf[i], 1'b1, i == nm_len - 1, nm_ovf, 1'b0));
        end
    endtask

    // One accepted byte through the parser; results land in step_res
    task automatic parse_byte(input t_in_item it);
        logic [7:0] c;
        string      kw;
        string      syn;
        c   = it.data_byte;
        kw  = (rkind == KIND_STYLE) ? "style" : "script";
        syn = (rkind == KIND_STYLE) ? "/style" : "/script";
        step_res.delete();
        if (it.req_type) begin
            if (pmode == M_NAME) push_name();
            reset_parser();
        end else begin
            case (pmode)
                M_NAME: begin
                    if (ends_name(c)) begin
                        push_name();
                        pmode = (c == CH_GT) ? mode_after_gt() : M_SKIP;
                    end else begin
                        if (nm_len < MAX_TAG_LEN) begin
                            nm_buf[nm_len] = c;
                            nm_len++;
                        end else begin
                            nm_ovf = 1'b1;
                        end
                        if (name_is("!--")) begin
                            dash_run = 0;
                            pmode    = M_COMMENT;
                        end
                    end
                end
                M_SKIP: begin
                    if (c == CH_GT) pmode = mode_after_gt();
                end
                M_COMMENT: begin
                    if (c == CH_DASH) begin
                        if (dash_run < 2) dash_run++;
                    end else if (c == CH_GT && dash_run >= 2) begin
                        dash_run = 0;
                        pmode    = M_TEXT;
                    end else begin
                        dash_run = 0;
                    end
                end
                M_RAW_WAIT: begin
                    if (c == CH_LT) pmode = M_RAW_LT;
                end
                M_RAW_LT: begin
                    if (c == CH_SLASH) begin
                        cl_pos  = 0;
                        cl_stat = CM_MATCHING;
                        pmode   = M_RAW_CLOSE;
                    end else if (c != CH_LT) begin
                        pmode = M_RAW_WAIT;
                    end
                end
                M_RAW_CLOSE: begin
                    if (c == CH_GT) begin
                        if (cl_stat != CM_FAILED && cl_pos == kw.len()) begin
                            for (int i = 0; i < syn.len(); i++)
                                step_res.push_back(mk_res(syn[i], 1'b1, i == syn.len() - 1,
                                                          1'b0, 1'b1));
                            pmode = M_TEXT;
                        end else begin
                            pmode = M_RAW_WAIT;
                        end
                    end else if (c == CH_LT) begin
                        pmode = M_RAW_LT;
                    end else if (cl_stat == CM_MATCHING) begin
                        if (cl_pos < kw.len() && c == kw[cl_pos]) cl_pos++;
                        else if (cl_pos == kw.len() && is_ws(c)) cl_stat = CM_SPACE;
                        else cl_stat = CM_FAILED;
                    end else if (cl_stat == CM_SPACE && !is_ws(c)) begin
                        cl_stat = CM_FAILED;
                    end
                end
                default: begin
                    if (c == CH_LT) begin
                        nm_len = 0;
                        nm_ovf = 1'b0;
                        pmode  = M_NAME;
                    end
                end
            endcase
        end
    endtask

    // Offer one item, wait for it to be taken, then queue what it should produce
    task automatic send_item(input t_in_item it, input logic [1:0] chk, input t_out_item res);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.item  <= it;
        do @(posedge i_clk); while (byte_ch.ready !== 1'b1);
        parse_byte(it);
        n_sent++;
        if (it.req_type) n_eos++;
        if (chk == CHK_NONE) begin
            step_res.delete();
        end else if (chk == CHK_ONE) begin
            step_res.delete();
            step_res.push_back(res);
        end
        foreach (step_res[j]) pending_chars.push_back(step_res[j]);
    endtask

    task automatic add_row(input logic rt, input logic [7:0] b, input logic [1:0] chk,
                           input t_out_item res);
        t_row r;
        r.item.req_type  = rt;
        r.item.data_byte = b;
        r.chk            = chk;
        r.res            = res;
        dir_rows.push_back(r);
    endtask

    task automatic put(input logic [7:0] b);
        t_in_item it;
        it.req_type  = 1'b0;
        it.data_byte = b;
        frag.push_back(it);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) put(s[i]);
    endtask

    // Mostly lowercase letters, sometimes any byte that does not end a name
    function automatic logic [7:0] name_char();
        logic [7:0] c;
        if ($urandom_range(0, 3) != 0) return 8'h61 + 8'($urandom_range(0, 25));
        c = 8'($urandom_range(1, 255));
        while (ends_name(c)) c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    // Receiver: random stalls, one long hold-off on request
    initial begin : char_sink
        char_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                char_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                char_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                char_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Compare each tag character taken with the oldest one expected
    always @(posedge i_clk) begin : char_check
        t_out_item got;
        t_out_item want;
        if (i_rst_n === 1'b1 && char_ch.valid === 1'b1 && char_ch.ready === 1'b1) begin
            got = char_ch.item;
            n_chars++;
            if (pending_chars.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("%0t unexpected result: char %h valid %b last %b trunc %b synth %b",
                             $time, got.tag_char, got.char_valid, got.last_of_tag,
                             got.name_truncated, got.synthetic_close);
            end else begin
                want = pending_chars.pop_front();
                if (got.tag_char !== want.tag_char || got.char_valid !== want.char_valid ||
                    got.last_of_tag !== want.last_of_tag ||
                    got.name_truncated !== want.name_truncated ||
                    got.synthetic_close !== want.synthetic_close) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("%0t mismatch: expected %h/%b/%b/%b/%b got %h/%b/%b/%b/%b",
                                 $time, want.tag_char, want.char_valid, want.last_of_tag,
                                 want.name_truncated, want.synthetic_close,
                                 got.tag_char, got.char_valid, got.last_of_tag,
                                 got.name_truncated, got.synthetic_close);
                end
                if (want.last_of_tag) begin
                    n_names++;
                    if (want.synthetic_close) n_synth++;
                    if (want.name_truncated) n_trunc++;
                end
            end
        end
    end

    // Watchdog: too long without any item moving on either channel
    always @(posedge i_clk) begin : watchdog
        if ((byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) ||
            (char_ch.valid === 1'b1 && char_ch.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("no item moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_chars.size());
            $display("html_tag_name_extractor_top test failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_out_item  none;
        t_out_item  empty_name;
        t_in_item   eos;
        logic [7:0] b;
        string      kw;
        int         goal;
        int         len;
        int         sel;
        logic       first;

        none       = '0;
        empty_name = mk_res(CH_NUL, 1'b0, 1'b1, 1'b0, 1'b0);
        byte_ch.valid <= 1'b0;
        byte_ch.item  <= '0;
        reset_parser();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Name cut short by end of stream, then an empty name ended by NUL
        add_row(1'b0, CH_LT,  CHK_MODEL, none);
        add_row(1'b0, 8'hFF,  CHK_MODEL, none);
        add_row(1'b1, 8'hFF,  CHK_ONE,   mk_res(8'hFF, 1'b1, 1'b1, 1'b0, 1'b0));
        add_row(1'b0, CH_LT,  CHK_MODEL, none);
        add_row(1'b0, CH_NUL, CHK_ONE,   empty_name);
        add_row(1'b0, CH_GT,  CHK_NONE,  none);
        // Comment: the opening dashes do not close it, two later ones do
        add_row(1'b0, CH_LT,   CHK_MODEL, none);
        add_row(1'b0, "!",     CHK_MODEL, none);
        add_row(1'b0, CH_DASH, CHK_MODEL, none);
        add_row(1'b0, CH_DASH, CHK_MODEL, none);
        add_row(1'b0, CH_GT,   CHK_NONE,  none);
        add_row(1'b0, CH_DASH, CHK_MODEL, none);
        add_row(1'b0, CH_DASH, CHK_MODEL, none);
        add_row(1'b0, CH_GT,   CHK_NONE,  none);
        // Style raw text, closed with trailing whitespace
        add_row(1'b0, CH_LT,   CHK_MODEL, none);
        add_row(1'b0, "s",     CHK_MODEL, none);
        add_row(1'b0, "t",     CHK_MODEL, none);
        add_row(1'b0, "y",     CHK_MODEL, none);
        add_row(1'b0, "l",     CHK_MODEL, none);
        add_row(1'b0, "e",     CHK_MODEL, none);
        add_row(1'b0, CH_GT,   CHK_MODEL, none);
        add_row(1'b0, CH_LT,   CHK_MODEL, none);
        add_row(1'b0, CH_SLASH, CHK_MODEL, none);
        add_row(1'b0, "s",     CHK_MODEL, none);
        add_row(1'b0, "t",     CHK_MODEL, none);
        add_row(1'b0, "y",     CHK_MODEL, none);
        add_row(1'b0, "l",     CHK_MODEL, none);
        add_row(1'b0, "e",     CHK_MODEL, none);
        add_row(1'b0, CH_TAB,  CHK_MODEL, none);
        add_row(1'b0, CH_GT,   CHK_MODEL, none);
        foreach (dir_rows[r]) send_item(dir_rows[r].item, dir_rows[r].chk, dir_rows[r].res);

        // Random fragments; the receiver holds off at the start while a long name goes in
        goal     = n_sent + RAND_ITEMS;
        hold_req = 1'b1;
        first    = 1'b1;
        while (n_sent < goal) begin
            frag.delete();
            sel = first ? 1 : $urandom_range(0, 11);
            case (sel)
                0: begin
                    // plain text
                    repeat ($urandom_range(1, 4)) begin
                        b = 8'($urandom_range(0, 255));
                        if (b == CH_LT) b = "t";
                        put(b);
                    end
                end
                1, 2, 3, 4: begin
                    // tag, sometimes with attributes, sometimes empty or too long
                    put(CH_LT);
                    if (!first && $urandom_range(0, 5) == 0) put(CH_SLASH);
                    sel = $urandom_range(0, 19);
                    if (first)          len = 40;
                    else if (sel == 0)  len = $urandom_range(MAX_TAG_LEN + 1, 40);
                    else if (sel == 1)  len = MAX_TAG_LEN;
                    else if (sel == 2)  len = 0;
                    else                len = $urandom_range(1, 8);
                    repeat (len) put(name_char());
                    if ($urandom_range(0, 1)) begin
                        case ($urandom_range(0, 4))
                            0: put(CH_SP);
                            1: put(CH_BRK);
                            2: put(CH_LF);
                            3: put(CH_CR);
                            default: put(CH_NUL);
                        endcase
                        repeat ($urandom_range(0, 3)) begin
                            b = 8'($urandom_range(0, 255));
                            if (b == CH_GT) b = "a";
                            put(b);
                        end
                    end
                    put(CH_GT);
                end
                5, 6: begin
                    // comment with dashes and stray '>' inside
                    put_str("<!--");
                    repeat ($urandom_range(0, 5)) begin
                        case ($urandom_range(0, 3))
                            0: put(CH_DASH);
                            1: put(CH_GT);
                            2: put("x");
                            default: put(8'($urandom_range(0, 255)));
                        endcase
                    end
                    if ($urandom_range(0, 1)) put_str("--->");
                    else put_str("-->");
                end
                7, 8: begin
                    // script or style raw text with near-miss closes
                    kw = $urandom_range(0, 1) ? "style" : "script";
                    put(CH_LT);
                    put_str(kw);
                    put(CH_GT);
                    repeat ($urandom_range(0, 6)) begin
                        case ($urandom_range(0, 5))
                            0: put(CH_LT);
                            1: put(CH_SLASH);
                            2: put(kw[$urandom_range(0, kw.len() - 1)]);
                            3: put(CH_SP);
                            4: put(CH_GT);
                            default: put(8'($urandom_range(0, 255)));
                        endcase
                    end
                    if ($urandom_range(0, 2) == 0) begin
                        // wrong case must not close
                        put(CH_LT);
                        put(CH_SLASH);
                        put(kw[0] - 8'h20);
                        for (int i = 1; i < kw.len(); i++) put(kw[i]);
                        put(CH_GT);
                    end
                    put(CH_LT);
                    put(CH_SLASH);
                    put_str(kw);
                    repeat ($urandom_range(0, 2)) begin
                        case ($urandom_range(0, 5))
                            0: put(CH_SP);
                            1: put(CH_TAB);
                            2: put(CH_LF);
                            3: put(CH_VT);
                            4: put(CH_FF);
                            default: put(CH_CR);
                        endcase
                    end
                    put(CH_GT);
                end
                9, 10: begin
                    // raw noise
                    repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)));
                end
                default: begin
                    // end of stream, often in the middle of a name
                    if ($urandom_range(0, 1)) begin
                        put(CH_LT);
                        repeat ($urandom_range(0, 3)) put(name_char());
                    end
                    eos.req_type  = 1'b1;
                    eos.data_byte = 8'($urandom_range(0, 255));
                    frag.push_back(eos);
                end
            endcase
            first = 1'b0;
            foreach (frag[j]) begin
                idle_on = (n_sent < goal - CALM_ITEMS);
                send_item(frag[j], CHK_MODEL, none);
            end
        end
        byte_ch.valid <= 1'b0;

        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes and %0d end-of-stream markers; checked %0d tag characters.",
                 n_sent - n_eos, n_eos, n_chars);
        $display("Names: %0d, truncated: %0d, generated closes: %0d, mismatches: %0d.",
                 n_names, n_trunc, n_synth, n_err);
        if (n_err == 0)
            $display("html_tag_name_extractor_top test passed");
        else
            $display("html_tag_name_extractor_top test failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/htne_pkg.sv
rtl/htne_ifs.sv
rtl/htne_cmd_fifo.sv
rtl/htne_front.sv
rtl/htne_back.sv
rtl/html_tag_name_extractor_top.sv
rtl/htne_checker.sv
tb/testbench.sv
